// File: rtl/core/clce_pkg.sv
// clce_pkg: shared types and constants for the CRLF line collector.
// Used by the front end, the command queue and the back end. No dependencies.
package clce_pkg;

    localparam logic [7:0] BYTE_CR = 8'h0d;
    localparam logic [7:0] BYTE_LF = 8'h0a;

    // Entries in the command queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_STORE    = 2'd0,
        CMD_DISCARD  = 2'd1,
        CMD_COMPLETE = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
        cmd_t head;
    } q_stat_t;

endpackage

// File: rtl/core/clce_rx_if.sv
// clce_rx_if: valid/ready channel carrying one received byte per word.
// Depends on nothing.
interface clce_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/clce_echo_if.sv
// clce_echo_if: valid/ready channel carrying one echoed byte per word.
// Depends on nothing.
interface clce_echo_if;
    logic       valid;
    logic       ready;
    logic [7:0] echo_byte;
    logic       line_last;

    modport source (output valid, output echo_byte, output line_last, input ready);
    modport sink   (input valid, input echo_byte, input line_last, output ready);
endinterface

// File: rtl/core/clce_front.sv
// clce_front: accepts received bytes, tracks the carriage-return flag and
// turns each byte but an absorbed CR into a command. Depends on clce_pkg, clce_rx_if.
module clce_front
    import clce_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    clce_rx_if.sink       rx,
    input  q_stat_t       q_stat,
    output q_push_t       q_push
);

    logic ret_reg;
    logic ret_next;
    logic accept;

    assign rx.ready = !q_stat.full;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        ret_next         = ret_reg;
        q_push.valid     = 1'b0;
        q_push.cmd.op    = CMD_STORE;
        q_push.cmd.data  = rx.rx_byte;
        if (accept)
        begin
            if (ret_reg)
            begin
                ret_next      = 1'b0;
                q_push.valid  = 1'b1;
                q_push.cmd.op = (rx.rx_byte == BYTE_LF) ? CMD_COMPLETE : CMD_DISCARD;
            end
            else if (rx.rx_byte == BYTE_CR)
            begin
                ret_next = 1'b1;
            end
            else
            begin
                q_push.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ret_reg <= 1'b0;
        else
            ret_reg <= ret_next;
    end

endmodule

// File: rtl/core/clce_queue.sv
// clce_queue: short command queue between front and back end.
// Depends on clce_pkg.
module clce_queue
    import clce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t q_push,
    input  logic    pop,
    output q_stat_t q_stat
);

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    fill_reg;
    logic [QPTR_W:0]    fill_next;
    logic               do_push;
    logic               do_pop;

    localparam logic [QPTR_W:0] FULL_FILL = (QPTR_W+1)'(QUEUE_DEPTH);

    assign do_push = q_push.valid && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    assign q_stat.full  = (fill_reg == FULL_FILL);
    assign q_stat.empty = (fill_reg == '0);
    assign q_stat.head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= q_push.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

endmodule

// File: rtl/core/clce_back.sv
// clce_back: line store, byte count and echo sequencer with output register.
// Depends on clce_pkg, clce_echo_if.
module clce_back
    import clce_pkg::*;
#(
    parameter int unsigned LINE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     q_stat,
    output logic        pop,
    clce_echo_if.source echo
);

    localparam int unsigned CNT_W = $clog2(LINE_DEPTH);
    localparam logic [CNT_W:0] DEPTH_V = (CNT_W+1)'(LINE_DEPTH);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_ECHO = 2'b10
    } back_state_t;

    logic [7:0]       mem [LINE_DEPTH];

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             rd_last_reg, rd_last_next;
    logic [7:0]       rd_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg;
    logic [7:0]       out_byte_reg;

    logic             wr_en;
    logic             adv;
    logic             issue;
    logic             idx_last;
    logic [CNT_W:0]   count_inc;

    assign pop       = (state_reg == B_IDLE) && !q_stat.empty;
    assign wr_en     = pop && (q_stat.head.op == CMD_STORE);
    assign adv       = rd_pend_reg && (!out_valid_reg || echo.ready);
    assign issue     = (state_reg == B_ECHO) && (!rd_pend_reg || adv);
    assign idx_last  = (rd_idx_reg == count_reg - 1'b1);
    assign count_inc = {1'b0, count_reg} + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = rd_pend_reg;
        rd_last_next   = rd_last_reg;
        out_valid_next = out_valid_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    case (q_stat.head.op)
                        CMD_STORE:
                            count_next = (count_inc == DEPTH_V) ? '0 : count_inc[CNT_W-1:0];
                        CMD_DISCARD:
                            count_next = '0;
                        CMD_COMPLETE:
                        begin
                            rd_idx_next = '0;
                            if (count_reg != '0)
                                state_next = B_ECHO;
                        end
                        default:
                            count_next = count_reg;
                    endcase
                end
            end
            B_ECHO:
            begin
                if (issue)
                begin
                    rd_last_next = idx_last;
                    if (idx_last)
                    begin
                        state_next  = B_IDLE;
                        count_next  = '0;
                        rd_idx_next = '0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            default:
                state_next = B_IDLE;
        endcase

        if (issue)
            rd_pend_next = 1'b1;
        else if (adv)
            rd_pend_next = 1'b0;

        if (adv)
            out_valid_next = 1'b1;
        else if (echo.ready)
            out_valid_next = 1'b0;
    end

    // Line store: one write port for collection, one registered read for echo.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg] <= q_stat.head.data;
        if (issue)
            rd_data_reg <= mem[rd_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg <= rd_data_reg;
            out_last_reg <= rd_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign echo.valid     = out_valid_reg;
    assign echo.echo_byte = out_byte_reg;
    assign echo.line_last = out_last_reg;

endmodule

// File: rtl/core/crlf_line_collector_with_echo.sv
// crlf_line_collector_with_echo: top level of the CRLF line collector.
// Depends on clce_pkg, clce_rx_if, clce_echo_if, clce_front, clce_queue, clce_back.
//
//   channel  dir  payload                    word
//   rx       in   rx_byte[7:0]               one received byte
//   echo     out  echo_byte[7:0], line_last  one byte of a completed line
//
// The front end takes one byte per cycle while the four-entry command queue
// has room; a carriage return with none pending is absorbed in the front and
// queues nothing. The back end retires one store/discard command per cycle
// while idle; a completed line holds it in the echo state for one line-store
// read per byte, longer while echo stalls. The first echo word passes the
// queue, the line-store read register and the output register to the port.
// Reset is asynchronous, active low, and clears control state only; the line
// store is not cleared. A stall on echo backs up into the queue and then rx.
module crlf_line_collector_with_echo
    import clce_pkg::*;
#(
    parameter int unsigned LINE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    clce_rx_if.sink     rx,
    clce_echo_if.source echo
);

    q_push_t q_push;
    q_stat_t q_stat;
    logic    q_pop;

    // Front: classifies each byte against the pending carriage return.
    clce_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .q_stat (q_stat),
        .q_push (q_push)
    );

    // Queue: decouples byte intake from line echo.
    clce_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (q_pop),
        .q_stat (q_stat)
    );

    // Back: owns the line store and sequences the echo.
    clce_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .pop    (q_pop),
        .echo   (echo)
    );

`ifndef NO_ASSERTIONS
    // The front never offers a command into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.valid |-> !q_stat.full)
        else $error("command pushed into full queue");

    // The back never pops an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // An empty queue with no push stays empty.
    a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.empty && !q_push.valid) |=> q_stat.empty)
        else $error("queue filled without a push");
`endif

endmodule
